// ===== design/rcf_pkg.sv =====
package rcf_pkg;

  localparam int REG_FIELD_W = 4;
  localparam int DATA_W      = 32;
  localparam int FUNC_W      = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_MOVIMM  = 4'd0,
    FN_MOV     = 4'd1,
    FN_ADDIMM  = 4'd2,
    FN_ADD     = 4'd3,
    FN_SUB     = 4'd4,
    FN_AND     = 4'd5,
    FN_OR      = 4'd6,
    FN_XOR     = 4'd7,
    FN_NEG     = 4'd8,
    FN_NOT     = 4'd9,
    FN_NEUTRAL = 4'd10,
    FN_OTHER   = 4'd11
  } func_t;

endpackage

// ===== design/register_constant_folder.sv =====
// Constant propagation over a basic-block instruction stream. One instruction
// is taken per cycle unless out_ready stalls the pipeline. The value table
// is read into the stage 1 register at acceptance (with a bypass from the
// instruction one stage ahead), then the fold ALU runs between that register
// and the result register, where the table is updated. The result register
// decouples the output side, so a request is taken while a result waits if
// stage 1 is empty. Known bits reset to zero; values are used only if known.
module register_constant_folder #(
  parameter int REG_COUNT = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rcf_pkg::FUNC_W-1:0]        in_func,
  input  logic [rcf_pkg::REG_FIELD_W-1:0]   in_dest_reg,
  input  logic [rcf_pkg::REG_FIELD_W-1:0]   in_src_reg,
  input  logic signed [rcf_pkg::DATA_W-1:0] in_immediate,
  input  logic                              in_block_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_folded,
  output logic [rcf_pkg::REG_FIELD_W-1:0]   out_fold_dest,
  output logic [rcf_pkg::DATA_W-1:0]        out_fold_value
);
  import rcf_pkg::*;

  localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [DATA_W-1:0]      value_mem [REG_COUNT];
  logic [REG_COUNT-1:0]   known_r, known_nxt;

  // stage 1: captured request plus table read data
  logic                   s1_valid_r;
  logic [FUNC_W-1:0]      s1_func_r;
  logic [REG_FIELD_W-1:0] s1_dest_r, s1_src_r;
  logic [DATA_W-1:0]      s1_imm_r;
  logic                   s1_bstart_r;
  logic [DATA_W-1:0]      s1_a_r, s1_b_r;

  logic                   out_valid_r, out_folded_r;
  logic [REG_FIELD_W-1:0] out_dest_r;
  logic [DATA_W-1:0]      out_value_r;

  logic                   in_fire, s1_fire;
  logic                   dest_in_range, src_in_range;
  logic [IDX_W-1:0]       dest_idx, src_idx, in_dest_idx, in_src_idx;
  logic                   known_a, known_b;
  logic                   attempt, have, clear_tbl, wr_en;
  logic [DATA_W-1:0]      val;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  assign dest_in_range = 32'(s1_dest_r) < REG_COUNT;
  assign src_in_range  = 32'(s1_src_r) < REG_COUNT;
  assign dest_idx      = IDX_W'(s1_dest_r);
  assign src_idx       = IDX_W'(s1_src_r);
  assign in_dest_idx   = IDX_W'(in_dest_reg);
  assign in_src_idx    = IDX_W'(in_src_reg);

  assign known_a = !s1_bstart_r && dest_in_range && known_r[dest_idx];
  assign known_b = !s1_bstart_r && src_in_range && known_r[src_idx];

  always_comb begin
    attempt   = 1'b0;
    have      = 1'b0;
    clear_tbl = s1_bstart_r;
    val       = '0;
    case (s1_func_r)
      FN_MOVIMM: begin
        val = s1_imm_r;
      end
      FN_MOV, FN_NEG, FN_NOT: begin
        attempt = 1'b1;
        have    = known_b;
        if (s1_func_r == FN_MOV) begin
          val = s1_b_r;
        end else if (s1_func_r == FN_NEG) begin
          val = DATA_W'(0) - s1_b_r;
        end else begin
          val = ~s1_b_r;
        end
      end
      FN_ADDIMM: begin
        attempt = 1'b1;
        have    = known_a;
        val     = s1_a_r + s1_imm_r;
      end
      FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR: begin
        attempt = 1'b1;
        have    = known_a && known_b;
        case (s1_func_r)
          FN_ADD:  val = s1_a_r + s1_b_r;
          FN_SUB:  val = s1_a_r - s1_b_r;
          FN_AND:  val = s1_a_r & s1_b_r;
          FN_OR:   val = s1_a_r | s1_b_r;
          default: val = s1_a_r ^ s1_b_r;
        endcase
      end
      FN_NEUTRAL: begin
      end
      default: begin
        clear_tbl = 1'b1;
      end
    endcase
  end

  assign wr_en = s1_fire && dest_in_range &&
                 ((s1_func_r == FN_MOVIMM) || (attempt && have));

  always_comb begin
    known_nxt = clear_tbl ? '0 : known_r;
    if (dest_in_range) begin
      if ((s1_func_r == FN_MOVIMM) || (attempt && have)) begin
        known_nxt[dest_idx] = 1'b1;
      end else if (attempt) begin
        known_nxt[dest_idx] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        known_r <= known_nxt;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // table write and read; bypass covers the instruction leaving stage 1
  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_mem[dest_idx] <= val;
    end
    if (in_fire) begin
      s1_func_r   <= in_func;
      s1_dest_r   <= in_dest_reg;
      s1_src_r    <= in_src_reg;
      s1_imm_r    <= DATA_W'(in_immediate);
      s1_bstart_r <= in_block_start;
      s1_a_r      <= (wr_en && in_dest_idx == dest_idx) ? val : value_mem[in_dest_idx];
      s1_b_r      <= (wr_en && in_src_idx == dest_idx) ? val : value_mem[in_src_idx];
    end
    if (s1_fire) begin
      out_folded_r <= have;
      out_dest_r   <= have ? s1_dest_r : '0;
      out_value_r  <= have ? val : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_folded     = out_folded_r;
  assign out_fold_dest  = out_dest_r;
  assign out_fold_value = out_value_r;

endmodule
